FILE: rtl/bbfc_pkg.sv
// ----------------------------------------------------------------------------
// bbfc_pkg
// types and constants shared by the frame cache modules
// ----------------------------------------------------------------------------
package bbfc_pkg;

  localparam int unsigned EntriesDef    = 32;
  localparam int unsigned WindowBitsDef = 4;
  localparam int unsigned TotalW        = 37;
  localparam logic [36:0] MaxBytesRst   = 37'd1073741824;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_CLR_WIN = 3'd3,
    KIND_CLR_ALL = 3'd4,
    KIND_PURGE  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         window_id;
    logic signed [31:0] frame;
    logic [31:0]        item_bytes;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  evicted_count;
    logic [36:0] total_bytes;
    logic [5:0]  entry_count;
  } out_item_t;

  // per-cell entry contents (ages are kept as order in the chain)
  typedef struct packed {
    logic        valid;
    logic [7:0]  window;
    logic [31:0] frame;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/bbfc_cell.sv
// ----------------------------------------------------------------------------
// bbfc_cell
// one slot of the age-ordered entry chain; shifts toward either end
// ----------------------------------------------------------------------------
module bbfc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,   // take neighbour entry (shift)
  input  logic             kill_i,   // drop own entry
  input  logic             upd_i,    // replace size
  input  logic [31:0]      size_i,
  input  bbfc_pkg::entry_t prev_i,
  output bbfc_pkg::entry_t ent_o
);

  logic        valid_q;
  logic [7:0]  window_q;
  logic [31:0] frame_q;
  logic [31:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= prev_i.valid;
    end else if (kill_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      window_q <= prev_i.window;
      frame_q  <= prev_i.frame;
      size_q   <= prev_i.size;
    end else if (upd_i) begin
      size_q <= size_i;
    end
  end

  assign ent_o = '{valid: valid_q, window: window_q, frame: frame_q, size: size_q};

endmodule

FILE: rtl/byte_budget_frame_cache_core.sv
// ----------------------------------------------------------------------------
// byte_budget_frame_cache_core
// byte-budgeted frame cache with oldest-first eviction
//
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_stall_o
//  out     | output    | out_valid_o / out_stall_i
//  apb     | input     | psel/penable/pwrite, pready tied high
//
// entries sit in a chain of cells, newest at cell 0, oldest at the far end.
// an item takes a scan over positions 0 to ENTRIES, then an insertion step
// for a new add, the budget evictions, a settle step, the compaction shifts
// and a final output step; the next item is taken once the core is back in
// idle. reset empties the chain at once; a stalled result holds the next item
// in its final cycle.
// ----------------------------------------------------------------------------
module byte_budget_frame_cache_core #(
  parameter int unsigned ENTRIES     = bbfc_pkg::EntriesDef,
  parameter int unsigned WINDOW_BITS = bbfc_pkg::WindowBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bbfc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bbfc_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam int unsigned PosW    = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW    = $clog2(ENTRIES);
  localparam logic [7:0]  WinMask = 8'((9'd1 << WINDOW_BITS) - 9'd1);

  // ---------------- configuration
  logic [36:0] max_bytes_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= bbfc_pkg::MaxBytesRst;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      max_bytes_q <= pwdata[36:0];
    end
  end
  assign prdata = (paddr == 1'b0) ? {27'd0, max_bytes_q} : 64'd0;

  // ---------------- state
  bbfc_pkg::state_e   state_q, state_d;
  bbfc_pkg::in_item_t item_q;
  logic [PosW-1:0]    pos_q;        // scan position (cell index)
  logic [36:0]        total_q;
  logic [5:0]         evict_q;
  logic               hit_q;
  logic               fresh_q;      // set when this item added a new entry
  bbfc_pkg::out_item_t out_q;
  logic               out_valid_q;

  bbfc_pkg::entry_t ent   [ENTRIES];
  bbfc_pkg::entry_t prev  [ENTRIES];
  logic [ENTRIES-1:0] load, kill, upd;

  logic [7:0] key_w;
  assign key_w = {4'd0, item_q.window_id} & WinMask;

  // the scan walks from the newest cell to the oldest one, one cell a cycle,
  // deciding kills; compaction then closes the holes toward cell 0
  logic [ENTRIES-1:0] match;
  logic [IdxW-1:0]    oldest_idx;   // highest valid index
  logic               any_valid;
  logic               full;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_match
    assign match[i] = ent[i].valid && ent[i].window == key_w &&
                      ent[i].frame == item_q.frame;
  end

  always_comb begin
    oldest_idx = '0;
    any_valid  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent[i].valid) begin
        oldest_idx = IdxW'(i);
        any_valid  = 1'b1;
      end
    end
  end
  assign full = ent[ENTRIES-1].valid;

  // one cell a cycle: the cell at pos decides kill by kind
  logic cur_kill;
  always_comb begin
    cur_kill = 1'b0;
    case (bbfc_pkg::kind_e'(item_q.kind))
      bbfc_pkg::KIND_REMOVE:  cur_kill = match[pos_q[IdxW-1:0]];
      bbfc_pkg::KIND_CLR_WIN: cur_kill = ent[pos_q[IdxW-1:0]].valid &&
                                         ent[pos_q[IdxW-1:0]].window == key_w;
      bbfc_pkg::KIND_CLR_ALL: cur_kill = ent[pos_q[IdxW-1:0]].valid;
      default:                cur_kill = 1'b0;
    endcase
  end

  logic [ENTRIES-1:0] hole;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hole[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        if (!ent[j].valid) hole[i] = 1'b1;
      end
    end
  end

  logic is_add, add_new, do_evict, out_load;
  assign is_add  = item_q.kind == bbfc_pkg::KIND_ADD;
  assign add_new = is_add && !hit_q;

  logic [IdxW-1:0] hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) hit_idx = IdxW'(i);
    end
  end

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != bbfc_pkg::ST_IDLE;

  // chain wiring: shift toward the old end on insert; compaction shifts the
  // upper part down over holes (done repeatedly while an empty cell sits below a valid one)
  logic ins_q;  // insertion cycle
  logic has_gap;
  always_comb begin
    has_gap = 1'b0;
    for (int i = 0; i < ENTRIES - 1; i++) begin
      if (!ent[i].valid && ent[i+1].valid) has_gap = 1'b1;
    end
  end

  // budget eviction only follows an add or a purge
  assign do_evict = state_q == bbfc_pkg::ST_EVICT && !ins_q &&
                    (is_add || item_q.kind == bbfc_pkg::KIND_PURGE) &&
                    total_q > max_bytes_q && any_valid;
  assign out_load = state_q == bbfc_pkg::ST_DONE && !has_gap &&
                    (!out_valid_q || !out_stall_i);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = ins_q ? bbfc_pkg::entry_t'{valid: 1'b1, window: key_w,
                                                  frame: item_q.frame,
                                                  size: item_q.item_bytes}
                             : ent[1 % ENTRIES];
    end else begin : g_body
      assign prev[i] = ins_q ? ent[i-1]
                             : ((i == ENTRIES - 1) ? '0 : ent[(i+1) % ENTRIES]);
    end
    assign load[i] = ins_q || (state_q == bbfc_pkg::ST_DONE && has_gap && hole[i]);
    assign kill[i] = (state_q == bbfc_pkg::ST_SCAN && pos_q == PosW'(i) && cur_kill) ||
                     (do_evict && oldest_idx == IdxW'(i)) ||
                     (state_q == bbfc_pkg::ST_SCAN && pos_q == PosW'(ENTRIES) &&
                      add_new && full && i == ENTRIES - 1);
    assign upd[i]  = state_q == bbfc_pkg::ST_SCAN && pos_q == PosW'(ENTRIES) &&
                     is_add && hit_q && hit_idx == IdxW'(i);
    bbfc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (load[i]),
      .kill_i (kill[i]),
      .upd_i  (upd[i]),
      .size_i (item_q.item_bytes),
      .prev_i (prev[i]),
      .ent_o  (ent[i])
    );
  end

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbfc_pkg::ST_IDLE:  if (in_acc) state_d = bbfc_pkg::ST_SCAN;
      bbfc_pkg::ST_SCAN:  if (pos_q == PosW'(ENTRIES)) state_d = bbfc_pkg::ST_EVICT;
      bbfc_pkg::ST_EVICT: if (!ins_q && !do_evict) state_d = bbfc_pkg::ST_DONE;
      bbfc_pkg::ST_DONE:  if (out_load) state_d = bbfc_pkg::ST_IDLE;
      default:            state_d = bbfc_pkg::ST_IDLE;
    endcase
  end

  // valid cells form a prefix once compaction has finished
  logic [5:0] cnt_now;
  assign cnt_now = any_valid ? 6'(oldest_idx) + 6'd1 : 6'd0;

  // oldest-end kill during eviction: is it the fresh entry (cell 0 after insert)
  logic evict_fresh;
  assign evict_fresh = fresh_q && oldest_idx == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbfc_pkg::ST_IDLE;
      pos_q       <= '0;
      total_q     <= '0;
      evict_q     <= '0;
      hit_q       <= 1'b0;
      fresh_q     <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      ins_q   <= state_q == bbfc_pkg::ST_SCAN && pos_q == PosW'(ENTRIES) && add_new;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (out_load) begin
        out_q <= '{hit: hit_q, evicted_count: evict_q, total_bytes: total_q,
                   entry_count: cnt_now};
      end
      case (state_q)
        bbfc_pkg::ST_IDLE: begin
          pos_q   <= '0;
          evict_q <= '0;
          fresh_q <= 1'b0;
        end
        bbfc_pkg::ST_SCAN: begin
          if (pos_q == '0) hit_q <= |match;
          if (pos_q < PosW'(ENTRIES)) begin
            pos_q <= pos_q + PosW'(1);
            if (cur_kill) begin
              total_q <= total_q - 37'(ent[pos_q[IdxW-1:0]].size);
              evict_q <= evict_q + 6'd1;
            end
          end else begin
            if (item_q.kind == bbfc_pkg::KIND_CLR_ALL) total_q <= '0;
            if (is_add && hit_q)
              total_q <= total_q - 37'(ent[hit_idx].size) + 37'(item_q.item_bytes);
            if (add_new) begin
              fresh_q <= 1'b1;
              total_q <= total_q + 37'(item_q.item_bytes) -
                         (full ? 37'(ent[ENTRIES-1].size) : 37'd0);
              if (full) evict_q <= evict_q + 6'd1;
            end
          end
        end
        bbfc_pkg::ST_EVICT: begin
          if (do_evict) begin
            total_q <= total_q - 37'(ent[oldest_idx].size);
            if (!evict_fresh) evict_q <= evict_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
